/* rtl/core/tmcd_pkg.sv */
package tmcd_pkg;

    localparam int MAX_MESSAGE_DEFAULT = 80;
    localparam int TOKEN_DEPTH = 7;
    localparam int OUT_DEPTH = 4;
    localparam logic [7:0] START_DUTY_RESET = 8'd255;
    localparam logic [7:0] MANOEUVRE_DUTY_RESET = 8'd250;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    typedef enum logic [3:0] {
        CFG_START_DUTY = 4'd0,
        CFG_MANOEUVRE_DUTY = 4'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_NOUN = 2'd0,
        MODE_ENGINE = 2'd1,
        MODE_UWB = 2'd2,
        MODE_DEAD = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        W_ENGINE = 4'd0,
        W_UWB = 4'd1,
        W_SEMI = 4'd2,
        W_START = 4'd3,
        W_STOP = 4'd4,
        W_RIGHT = 4'd5,
        W_LEFT = 4'd6,
        W_REVERSE = 4'd7,
        W_NONE = 4'd8
    } word_t;

    typedef enum logic [2:0] {
        EV_START = 3'd0,
        EV_STOP = 3'd1,
        EV_RIGHT = 3'd2,
        EV_LEFT = 3'd3,
        EV_REVERSE = 3'd4,
        EV_UWB_START = 3'd5,
        EV_UWB_STOP = 3'd6,
        EV_INVALID = 3'd7
    } event_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] left_duty;
        logic [7:0] right_duty;
        logic       left_forward;
        logic       right_forward;
        logic       final_result;
    } out_t;

    typedef struct packed {
        logic [7:0] start_duty;
        logic [7:0] manoeuvre_duty;
    } cfg_t;

    typedef struct packed {
        logic [7:0] duty_one;
        logic [7:0] duty_two;
        logic [1:0] dirs;
    } motor_t;

    typedef struct packed {
        mode_t  mode;
        motor_t motor;
        logic   emit;
        event_t ev;
    } tok_res_t;

    typedef struct packed {
        logic [1:0] count;
        out_t       first;
        out_t       second;
    } push_t;

    typedef logic [TOKEN_DEPTH-1:0][7:0] token_t;

    localparam logic [55:0] WORD_TEXT [8] = '{
        56'("engine"), 56'("uwb"), 56'(";"), 56'("start"),
        56'("stop"), 56'("right"), 56'("left"), 56'("reverse")
    };
    localparam logic [3:0] WORD_LEN [8] = '{
        4'd6, 4'd3, 4'd1, 4'd5, 4'd4, 4'd5, 4'd4, 4'd7
    };

    function automatic word_t classify(input token_t text, input logic [3:0] len);
        word_t w;
        logic  hit;
        w = W_NONE;
        for (int i = 7; i >= 0; i--) begin
            hit = (len == WORD_LEN[i]);
            for (int k = 0; k < TOKEN_DEPTH; k++) begin
                if (4'(k) < WORD_LEN[i]) begin
                    if (text[k] != WORD_TEXT[i][8*(int'(WORD_LEN[i]) - 1 - k) +: 8]) begin
                        hit = 1'b0;
                    end
                end
            end
            if (hit) begin
                w = word_t'(4'(i));
            end
        end
        return w;
    endfunction

    function automatic tok_res_t end_token(input mode_t mode, input word_t w,
                                           input motor_t motor, input cfg_t cfg);
        tok_res_t r;
        logic     done;
        r.mode = mode;
        r.motor = motor;
        r.emit = 1'b0;
        r.ev = EV_INVALID;
        done = 1'b0;
        if (mode == MODE_ENGINE) begin
            r.mode = MODE_NOUN;
            done = 1'b1;
            unique case (w)
                W_START: begin
                    r.motor = '{cfg.start_duty, cfg.start_duty, 2'b11};
                    r.ev = EV_START;
                end
                W_STOP: begin
                    r.motor = '{8'd0, 8'd0, motor.dirs};
                    r.ev = EV_STOP;
                end
                W_RIGHT: begin
                    r.motor = '{cfg.manoeuvre_duty, cfg.manoeuvre_duty, 2'b01};
                    r.ev = EV_RIGHT;
                end
                W_LEFT: begin
                    r.motor = '{cfg.manoeuvre_duty, cfg.manoeuvre_duty, 2'b10};
                    r.ev = EV_LEFT;
                end
                W_REVERSE: begin
                    r.motor = '{cfg.manoeuvre_duty, cfg.manoeuvre_duty, 2'b00};
                    r.ev = EV_REVERSE;
                end
                default: begin
                    done = 1'b0;
                end
            endcase
            r.emit = done;
        end else if (mode == MODE_UWB) begin
            r.mode = MODE_NOUN;
            if (w == W_START) begin
                done = 1'b1;
                r.ev = EV_UWB_START;
            end else if (w == W_STOP) begin
                done = 1'b1;
                r.ev = EV_UWB_STOP;
            end
            r.emit = done;
        end
        if (!done && r.mode == MODE_NOUN) begin
            if (w == W_ENGINE) begin
                r.mode = MODE_ENGINE;
            end else if (w == W_UWB) begin
                r.mode = MODE_UWB;
            end else if (w != W_SEMI) begin
                r.emit = 1'b1;
                r.ev = EV_INVALID;
                r.mode = MODE_DEAD;
            end
        end
        return r;
    endfunction

    function automatic out_t make_result(input event_t ev, input motor_t motor,
                                         input logic fin);
        out_t o;
        o.event_res = ev;
        o.left_duty = motor.duty_one;
        o.right_duty = motor.duty_two;
        o.left_forward = motor.dirs[0];
        o.right_forward = motor.dirs[1];
        o.final_result = fin;
        return o;
    endfunction

endpackage

/* rtl/core/tmcd_parser.sv */
module tmcd_parser
    import tmcd_pkg::*;
#(
    parameter int MAX_MESSAGE = MAX_MESSAGE_DEFAULT
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    input  in_t   in_data,
    input  cfg_t  cfg,
    output push_t push
);

    localparam int BT_W = $clog2(MAX_MESSAGE + 1);
    localparam logic [BT_W-1:0] MAX_CNT = BT_W'(MAX_MESSAGE);

    token_t          tok_text_reg, tok_text_next;
    logic [3:0]      tok_len_reg, tok_len_next;
    mode_t           mode_reg, mode_next;
    logic            after_space_reg, after_space_next;
    logic            ended_reg, ended_next;
    logic [BT_W-1:0] bytes_reg, bytes_next;
    motor_t          motor_reg, motor_next;

    logic     blank, nul, cap, c1_en, c2_en;
    token_t   app_text;
    logic [3:0] app_len;
    word_t    c1_word;
    tok_res_t c1, c2;
    mode_t    mode_mid;
    motor_t   motor_mid;
    logic     e1, e2;
    logic [7:0] b;

    always_comb begin
        b = in_data.data_byte;
        nul = (b == CHAR_NUL);
        blank = (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
        bytes_next = bytes_reg + 1'b1;
        cap = !nul && (bytes_next >= MAX_CNT);

        app_text = tok_text_reg;
        app_len = tok_len_reg;
        if (tok_len_reg < 4'(TOKEN_DEPTH)) begin
            app_text[tok_len_reg[2:0]] = b;
            app_len = tok_len_reg + 4'd1;
        end else begin
            app_len = 4'd8;
        end

        c1_word = (nul || blank) ? classify(tok_text_reg, tok_len_reg)
                                 : classify(app_text, app_len);
        c1_en = !ended_reg && (nul || (blank && !after_space_reg) || cap
                               || in_data.last_byte);
        c2_en = !ended_reg && !nul && blank && !after_space_reg
                && (cap || in_data.last_byte);

        c1 = end_token(mode_reg, c1_word, motor_reg, cfg);
        mode_mid = c1_en ? c1.mode : mode_reg;
        motor_mid = c1_en ? c1.motor : motor_reg;
        c2 = end_token(mode_mid, W_NONE, motor_mid, cfg);
        e1 = c1_en && c1.emit;
        e2 = c2_en && c2.emit;
        mode_next = c2_en ? c2.mode : mode_mid;
        motor_next = c2_en ? c2.motor : motor_mid;
    end

    always_comb begin
        tok_text_next = tok_text_reg;
        tok_len_next = tok_len_reg;
        after_space_next = after_space_reg;
        ended_next = ended_reg;
        if (!ended_reg) begin
            if (nul) begin
                tok_len_next = 4'd0;
                ended_next = 1'b1;
            end else begin
                if (blank) begin
                    tok_len_next = 4'd0;
                    after_space_next = 1'b1;
                end else begin
                    tok_text_next = app_text;
                    tok_len_next = app_len;
                    after_space_next = 1'b0;
                end
                if (cap) begin
                    tok_len_next = 4'd0;
                    ended_next = 1'b1;
                end
            end
        end
    end

    always_comb begin
        push.count = 2'(e1) + 2'(e2);
        push.first = e1 ? make_result(c1.ev, c1.motor, !e2)
                        : make_result(c2.ev, c2.motor, 1'b1);
        push.second = make_result(c2.ev, c2.motor, 1'b1);
        if (!in_valid) begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_len_reg <= 4'd0;
            mode_reg <= MODE_NOUN;
            after_space_reg <= 1'b0;
            ended_reg <= 1'b0;
            bytes_reg <= '0;
            motor_reg <= '0;
        end else if (in_valid) begin
            motor_reg <= motor_next;
            if (in_data.last_byte) begin
                tok_len_reg <= 4'd0;
                mode_reg <= MODE_NOUN;
                after_space_reg <= 1'b0;
                ended_reg <= 1'b0;
                bytes_reg <= '0;
            end else begin
                tok_len_reg <= tok_len_next;
                mode_reg <= mode_next;
                after_space_reg <= after_space_next;
                ended_reg <= ended_next;
                if (!ended_reg) begin
                    bytes_reg <= bytes_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            tok_text_reg <= tok_text_next;
        end
    end

endmodule

/* rtl/core/tmcd_out_fifo.sv */
module tmcd_out_fifo
    import tmcd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  push_t push,
    output logic  room,
    output logic  m_valid,
    input  logic  m_ready,
    output out_t  m_data
);

    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    out_t             mem_reg [OUT_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;

    always_comb begin
        m_valid = (cnt_reg != '0);
        pop = m_valid && m_ready;
        wr_next = wr_reg + PTR_W'(push.count);
        rd_next = rd_reg + PTR_W'(pop);
        cnt_next = cnt_reg + CNT_W'(push.count) - CNT_W'(pop);
        room = (cnt_reg <= CNT_W'(OUT_DEPTH - 2));
        m_data = mem_reg[rd_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_reg + PTR_W'(1)] <= push.second;
        end
    end

endmodule

/* rtl/core/text_motor_command_decoder_core.sv */
// Results enter the output queue as their byte is accepted. Throughput: one byte per cycle
// while s_ready is high; a byte may give up to two results, drained one per cycle while m_ready
// is high from a four-entry output queue, and s_ready stays high while two entries are free.
// Reset: synchronous, active low; clears the parse state, the motor state and the queue,
// and loads the duty registers with 255 and 250. Configuration writes complete at once.
module text_motor_command_decoder_core
    import tmcd_pkg::*;
#(
    parameter int MAX_MESSAGE = MAX_MESSAGE_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_t        s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_t       m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cfg_t  cfg_reg;
    push_t push;
    logic  room;
    logic  accept;

    assign cfg_ready = 1'b1;
    assign s_ready = room;
    assign accept = s_valid && room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_duty <= START_DUTY_RESET;
            cfg_reg.manoeuvre_duty <= MANOEUVRE_DUTY_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_START_DUTY) begin
                cfg_reg.start_duty <= cfg_data;
            end else if (cfg_index == CFG_MANOEUVRE_DUTY) begin
                cfg_reg.manoeuvre_duty <= cfg_data;
            end
        end
    end

    tmcd_parser #(
        .MAX_MESSAGE(MAX_MESSAGE)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(accept),
        .in_data (s_data),
        .cfg     (cfg_reg),
        .push    (push)
    );

    tmcd_out_fifo u_out_fifo (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (push),
        .room   (room),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

endmodule

/* test/text_motor_command_decoder_core_tb.sv */
module text_motor_command_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmcd_pkg::*;

    localparam int MAX_MSG = MAX_MESSAGE_DEFAULT;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD = 60;
    localparam int REPORT_LIMIT = 10;
    localparam int PHASES = 6;
    localparam int BYTES_PER_PHASE = 215;
    localparam logic [3:0] CFG_NO_REGISTER = 4'd9;
    localparam out_t NO_RESULT = '0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       typed;
        out_t       result;
    } row_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_t        s_data;
    logic       m_valid;
    logic       m_ready;
    out_t       m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [3:0] cfg_index;
    logic [7:0] cfg_data;

    text_motor_command_decoder_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Decoder state as the testbench tracks it.
    logic [7:0]  kick_duty;
    logic [7:0]  turn_duty;
    logic [55:0] word_buf;
    logic [3:0]  word_len;
    mode_t       grammar;
    logic        in_blank;
    logic        text_done;
    int          msg_bytes;
    logic [7:0]  duty_left;
    logic [7:0]  duty_right;
    logic [1:0]  fwd;
    out_t        fresh [4];
    int          fresh_n;

    out_t        due_events [$];
    logic [7:0]  msg [$];
    row_t        script [23];

    logic        typed_pending = 1'b0;
    out_t        typed_value = '0;
    logic        long_hold_req = 1'b0;
    logic        sender_gaps = 1'b0;
    logic        receiver_gaps = 1'b0;

    int          errors = 0;
    int          beats_in = 0;
    int          live_beats = 0;
    int          results_checked = 0;
    int          messages = 0;
    int          quiet_cycles = 0;

    function void forget_message();
        word_buf = '0;
        word_len = 4'd0;
        grammar = MODE_NOUN;
        in_blank = 1'b0;
        text_done = 1'b0;
        msg_bytes = 0;
    endfunction

    function void steer(input logic [7:0] duty, input logic [1:0] dirs);
        duty_left = duty;
        duty_right = duty;
        fwd = dirs;
    endfunction

    function void log_event(input event_t ev);
        fresh[fresh_n] = {ev, duty_left, duty_right, fwd[0], fwd[1], 1'b0};
        fresh_n++;
    endfunction

    function void close_token();
        word_t w;
        w = W_NONE;
        if (word_len == 4'd6 && word_buf[47:0] == "engine") begin
            w = W_ENGINE;
        end else if (word_len == 4'd3 && word_buf[23:0] == "uwb") begin
            w = W_UWB;
        end else if (word_len == 4'd1 && word_buf[7:0] == ";") begin
            w = W_SEMI;
        end else if (word_len == 4'd5 && word_buf[39:0] == "start") begin
            w = W_START;
        end else if (word_len == 4'd4 && word_buf[31:0] == "stop") begin
            w = W_STOP;
        end else if (word_len == 4'd5 && word_buf[39:0] == "right") begin
            w = W_RIGHT;
        end else if (word_len == 4'd4 && word_buf[31:0] == "left") begin
            w = W_LEFT;
        end else if (word_len == 4'd7 && word_buf[55:0] == "reverse") begin
            w = W_REVERSE;
        end
        word_len = 4'd0;
        word_buf = '0;
        if (grammar == MODE_ENGINE) begin
            grammar = MODE_NOUN;
            case (w)
                W_START: begin
                    steer(kick_duty, 2'b11);
                    log_event(EV_START);
                    return;
                end
                W_STOP: begin
                    steer(8'd0, fwd);
                    log_event(EV_STOP);
                    return;
                end
                W_RIGHT: begin
                    steer(turn_duty, 2'b01);
                    log_event(EV_RIGHT);
                    return;
                end
                W_LEFT: begin
                    steer(turn_duty, 2'b10);
                    log_event(EV_LEFT);
                    return;
                end
                W_REVERSE: begin
                    steer(turn_duty, 2'b00);
                    log_event(EV_REVERSE);
                    return;
                end
                default: begin
                end
            endcase
        end else if (grammar == MODE_UWB) begin
            grammar = MODE_NOUN;
            if (w == W_START) begin
                log_event(EV_UWB_START);
                return;
            end
            if (w == W_STOP) begin
                log_event(EV_UWB_STOP);
                return;
            end
        end
        if (grammar != MODE_NOUN) begin
            return;
        end
        if (w == W_ENGINE) begin
            grammar = MODE_ENGINE;
        end else if (w == W_UWB) begin
            grammar = MODE_UWB;
        end else if (w != W_SEMI) begin
            log_event(EV_INVALID);
            grammar = MODE_DEAD;
        end
    endfunction

    function void decode_byte(input in_t beat);
        logic [7:0] b;
        b = beat.data_byte;
        fresh_n = 0;
        if (!text_done) begin
            msg_bytes++;
            if (b == CHAR_NUL) begin
                close_token();
                text_done = 1'b1;
            end else begin
                if (b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR)) begin
                    if (!in_blank) begin
                        close_token();
                        in_blank = 1'b1;
                    end
                end else begin
                    in_blank = 1'b0;
                    if (word_len < 4'd7) begin
                        word_buf = {word_buf[47:0], b};
                        word_len = word_len + 4'd1;
                    end else begin
                        word_len = 4'd8;
                    end
                end
                if (msg_bytes >= MAX_MSG) begin
                    close_token();
                    text_done = 1'b1;
                end
            end
        end
        if (beat.last_byte) begin
            if (!text_done) begin
                close_token();
            end
            forget_message();
        end
    endfunction

    function logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    function logic [7:0] pick_char();
        logic [7:0] c;
        c = rand_byte();
        while (c == CHAR_NUL || c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
            c = rand_byte();
        end
        return c;
    endfunction

    function void put_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            msg.push_back(s[i]);
        end
    endfunction

    function void put_blanks();
        logic [31:0] r;
        int n;
        n = $urandom_range(1, 3);
        repeat (n) begin
            r = $urandom_range(0, 4);
            if ($urandom_range(0, 2) == 0) begin
                msg.push_back(CHAR_TAB + r[7:0]);
            end else begin
                msg.push_back(CHAR_SPACE);
            end
        end
    endfunction

    function string engine_verb(input int k);
        case (k)
            0: return "start";
            1: return "stop";
            2: return "right";
            3: return "left";
            default: return "reverse";
        endcase
    endfunction

    function string any_word(input int k);
        case (k)
            0: return "engine";
            1: return "uwb";
            2: return ";";
            8: return "engineer";
            9: return "stops";
            10: return "Left";
            default: return engine_verb(k - 3);
        endcase
    endfunction

    function void put_phrase();
        int r;
        int n;
        r = $urandom_range(0, 19);
        if (r < 11) begin
            put_text("engine");
            put_blanks();
            put_text(engine_verb($urandom_range(0, 4)));
        end else if (r < 15) begin
            put_text("uwb");
            put_blanks();
            put_text(engine_verb($urandom_range(0, 1)));
        end else if (r == 15) begin
            put_text(";");
        end else if (r < 18) begin
            put_text(any_word($urandom_range(0, 10)));
            put_blanks();
            put_text(any_word($urandom_range(0, 10)));
        end else begin
            n = $urandom_range(1, 9);
            repeat (n) msg.push_back(pick_char());
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                             input out_t value);
        in_t beat;
        int gap;
        beat.data_byte = b;
        beat.last_byte = fin;
        gap = 0;
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
        end
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        typed_pending = typed;
        typed_value = value;
        s_valid <= 1'b1;
        s_data <= beat;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_message();
        int shape;
        int ending;
        int n;
        msg.delete();
        shape = $urandom_range(0, 39);
        if (shape < 4) begin
            n = $urandom_range(1, 12);
            repeat (n) msg.push_back(rand_byte());
        end else begin
            if ($urandom_range(0, 9) == 0) begin
                put_blanks();
            end
            if (shape == 4) begin
                while (msg.size() < MAX_MSG + 4) begin
                    put_phrase();
                    put_blanks();
                end
            end else begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    if (i > 0) begin
                        put_blanks();
                    end
                    put_phrase();
                end
            end
            ending = $urandom_range(0, 7);
            if (ending == 0) begin
                put_blanks();
            end else if (ending == 1) begin
                msg.push_back(CHAR_NUL);
                n = $urandom_range(0, 3);
                repeat (n) msg.push_back(rand_byte());
            end
        end
        for (int i = 0; i < msg.size(); i++) begin
            send_byte(msg[i], i == msg.size() - 1, 1'b0, NO_RESULT);
        end
        messages++;
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [7:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_events.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        out_t want;
        out_t got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_START_DUTY) begin
                    kick_duty = cfg_data;
                end else if (cfg_index == CFG_MANOEUVRE_DUTY) begin
                    turn_duty = cfg_data;
                end
            end
            if (s_valid && s_ready) begin
                beats_in++;
                if (!text_done) begin
                    live_beats++;
                end
                decode_byte(s_data);
                if (typed_pending) begin
                    fresh[0] = typed_value;
                    fresh_n = 1;
                end
                for (int i = 0; i < fresh_n; i++) begin
                    want = fresh[i];
                    want.final_result = (i == fresh_n - 1);
                    due_events.push_back(want);
                end
            end
            if (m_valid && m_ready) begin
                got = m_data;
                results_checked++;
                if (due_events.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT) begin
                        $display("Unexpected result at %0t: ev %0d duty %0d/%0d fwd %0b/%0b fin %0b",
                                 $realtime, got.event_res, got.left_duty, got.right_duty,
                                 got.left_forward, got.right_forward, got.final_result);
                    end
                end else begin
                    want = due_events.pop_front();
                    if (got.event_res !== want.event_res || got.left_duty !== want.left_duty ||
                        got.right_duty !== want.right_duty ||
                        got.left_forward !== want.left_forward ||
                        got.right_forward !== want.right_forward ||
                        got.final_result !== want.final_result) begin
                        errors++;
                        if (errors <= REPORT_LIMIT) begin
                            $display("Mismatch at %0t: expected ev %0d duty %0d/%0d fwd %0b/%0b fin %0b",
                                     $realtime, want.event_res, want.left_duty, want.right_duty,
                                     want.left_forward, want.right_forward, want.final_result);
                            $display("                 got ev %0d duty %0d/%0d fwd %0b/%0b fin %0b",
                                     got.event_res, got.left_duty, got.right_duty,
                                     got.left_forward, got.right_forward, got.final_result);
                        end
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: no beat for %0d cycles, %0d results still owed",
                     WATCHDOG_LIMIT, due_events.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int target;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        kick_duty = START_DUTY_RESET;
        turn_duty = MANOEUVRE_DUTY_RESET;
        steer(8'd0, 2'b00);
        forget_message();

        // A leading blank closes an empty token, a zero byte closes one, and a blank on the
        // final byte closes the open token and then an empty one.
        script = '{
            {CHAR_SPACE, 1'b0, 1'b1, EV_INVALID, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1},
            {8'hFF,      1'b1, 1'b0, NO_RESULT},
            {CHAR_NUL,   1'b1, 1'b1, EV_INVALID, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1},
            {"e",        1'b0, 1'b0, NO_RESULT},
            {"n",        1'b0, 1'b0, NO_RESULT},
            {"g",        1'b0, 1'b0, NO_RESULT},
            {"i",        1'b0, 1'b0, NO_RESULT},
            {"n",        1'b0, 1'b0, NO_RESULT},
            {"e",        1'b0, 1'b0, NO_RESULT},
            {CHAR_TAB,   1'b0, 1'b0, NO_RESULT},
            {"l",        1'b0, 1'b0, NO_RESULT},
            {"e",        1'b0, 1'b0, NO_RESULT},
            {"f",        1'b0, 1'b0, NO_RESULT},
            {"t",        1'b0, 1'b0, NO_RESULT},
            {CHAR_CR,    1'b1, 1'b0, NO_RESULT},
            {"u",        1'b0, 1'b0, NO_RESULT},
            {"w",        1'b0, 1'b0, NO_RESULT},
            {"b",        1'b0, 1'b0, NO_RESULT},
            {CHAR_SPACE, 1'b0, 1'b0, NO_RESULT},
            {";",        1'b0, 1'b0, NO_RESULT},
            {CHAR_NUL,   1'b0, 1'b0, NO_RESULT},
            {8'h7F,      1'b0, 1'b0, NO_RESULT},
            {8'h80,      1'b1, 1'b0, NO_RESULT}
        };

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < 23; i++) begin
            send_byte(script[i].data_byte, script[i].last_byte, script[i].typed,
                      script[i].result);
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: begin
                    write_reg(CFG_START_DUTY, 8'd0);
                    write_reg(CFG_MANOEUVRE_DUTY, 8'd0);
                end
                1: begin
                    write_reg(CFG_START_DUTY, 8'd255);
                    write_reg(CFG_MANOEUVRE_DUTY, 8'd255);
                end
                2: begin
                    write_reg(CFG_NO_REGISTER, 8'hA5);
                    write_reg(CFG_START_DUTY, 8'd1);
                    write_reg(CFG_MANOEUVRE_DUTY, 8'd254);
                end
                default: begin
                    write_reg(CFG_START_DUTY, rand_byte());
                    write_reg(CFG_MANOEUVRE_DUTY, rand_byte());
                end
            endcase
            sender_gaps = (p == 1 || p == 2 || p == 4);
            receiver_gaps = (p == 0 || p == 2 || p == 4);
            if (p == 3) begin
                // Each lone blank message gives one result, so the output queue fills
                // while the receiver holds off.
                long_hold_req = 1'b1;
                repeat (24) send_byte(CHAR_SPACE, 1'b1, 1'b0, NO_RESULT);
            end
            target = live_beats + BYTES_PER_PHASE;
            while (live_beats < target) send_message();
        end
        settle();

        $display("Checked %0d results from %0d bytes in %0d random messages plus a directed set,",
                 results_checked, beats_in, messages);
        $display("over %0d duty settings with idle bursts and one long output stall.", PHASES);
        if (errors == 0 && due_events.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results still owed", errors, due_events.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
